FILE: hdl/lba_pkg.sv
// Shared constants and types of the linked block allocator.
`default_nettype none
package lba_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int NUM_FILES  = 32;

	localparam int BIDX_W  = $clog2(NUM_BLOCKS);
	localparam int FIDX_W  = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
	localparam int LINK_W  = 7;
	localparam int CNT_W   = 7;
	localparam int ID_W    = 8;
	localparam int SIZE_W  = 8;
	localparam int START_W = 6;
	localparam int STAT_W  = 3;

	localparam logic [LINK_W-1:0] LINK_END  = 7'd64;
	localparam logic [LINK_W-1:0] LINK_FREE = 7'd127;

	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOO_FEW   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;

	// Write request to the link table.
	typedef struct packed {
		logic              en;
		logic [BIDX_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	// Set or clear request to the file table.
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [FIDX_W-1:0] addr;
		logic [ID_W-1:0]   id;
		logic [BIDX_W-1:0] start;
	} file_wr_t;

	// Registered read data of the file table.
	typedef struct packed {
		logic              vld;
		logic [ID_W-1:0]   id;
		logic [BIDX_W-1:0] start;
	} file_rd_t;

endpackage
`default_nettype wire

FILE: hdl/lba_link_mem.sv
// Block link table: synchronous memory with per-entry valid bits.
`default_nettype none
module lba_link_mem (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [lba_pkg::BIDX_W-1:0]        rd_addr,
	input  wire lba_pkg::link_wr_t                 wr,
	output      logic [lba_pkg::LINK_W-1:0]        rd_data
);

	logic [lba_pkg::LINK_W-1:0] mem [lba_pkg::NUM_BLOCKS];
	logic [lba_pkg::NUM_BLOCKS-1:0] vld_q;
	logic [lba_pkg::LINK_W-1:0] rd_data_q;
	logic rd_vld_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Valid bits: an entry never written reads as free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : lba_pkg::LINK_FREE;

endmodule
`default_nettype wire

FILE: hdl/lba_file_mem.sv
// File table: synchronous memory of id and start block with valid bits.
`default_nettype none
module lba_file_mem (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [lba_pkg::FIDX_W-1:0] rd_addr,
	input  wire lba_pkg::file_wr_t          wr,
	output      lba_pkg::file_rd_t          rd
);

	logic [lba_pkg::ID_W-1:0]   id_mem    [lba_pkg::NUM_FILES];
	logic [lba_pkg::BIDX_W-1:0] start_mem [lba_pkg::NUM_FILES];
	logic [lba_pkg::NUM_FILES-1:0] vld_q;
	logic [lba_pkg::ID_W-1:0]   rd_id_q;
	logic [lba_pkg::BIDX_W-1:0] rd_start_q;
	logic rd_vld_q;

	// Payload storage and registered read.
	always_ff @(posedge clk) begin
		if (wr.set) begin
			id_mem[wr.addr]    <= wr.id;
			start_mem[wr.addr] <= wr.start;
		end
		rd_id_q    <= id_mem[rd_addr];
		rd_start_q <= start_mem[rd_addr];
	end

	// Slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.set) begin
				vld_q[wr.addr] <= 1'b1;
			end else if (wr.clr) begin
				vld_q[wr.addr] <= 1'b0;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd.vld   = rd_vld_q;
	assign rd.id    = rd_id_q;
	assign rd.start = rd_start_q;

endmodule
`default_nettype wire

FILE: hdl/linked_block_allocator.sv
// Top level of the linked block allocator: command sequencer and counters.
`default_nettype none
// One command is handled at a time. Every command other than a rejected
// create scans the file table, one slot a cycle. A create then scans the
// link table one block a cycle until enough free blocks are chained; a
// delete walks the chain through the link memory's single read port,
// with a read state and a check state for each block. A create with size
// zero or a full file table goes straight to the response state.
// The next command is accepted while the previous result beat still waits.
module linked_block_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic                        cmd,
	input  wire logic [lba_pkg::ID_W-1:0]    file_id,
	input  wire logic [lba_pkg::SIZE_W-1:0]  alloc_size,
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic [lba_pkg::STAT_W-1:0]  status,
	output      logic [lba_pkg::START_W-1:0] start_block,
	output      logic [lba_pkg::CNT_W-1:0]   blocks_used
);

	typedef enum logic [3:0] {
		S_IDLE, S_FSCAN, S_DECIDE, S_ASCAN, S_AEND, S_WRD, S_WCK, S_WFIN, S_RESP
	} state_t;

	state_t state_q;

	logic                        cmd_q;
	logic [lba_pkg::ID_W-1:0]    id_q;
	logic [lba_pkg::SIZE_W-1:0]  size_q;
	logic [lba_pkg::FIDX_W:0]    sidx_q;
	logic                        found_q;
	logic [lba_pkg::FIDX_W-1:0]  mslot_q;
	logic [lba_pkg::BIDX_W-1:0]  fstart_q;
	logic                        hole_q;
	logic [lba_pkg::FIDX_W-1:0]  hslot_q;
	logic [lba_pkg::BIDX_W:0]    bidx_q;
	logic [lba_pkg::CNT_W-1:0]   taken_q;
	logic [lba_pkg::BIDX_W-1:0]  first_q;
	logic [lba_pkg::BIDX_W-1:0]  prev_q;
	logic [lba_pkg::LINK_W-1:0]  cur_q;
	logic [lba_pkg::CNT_W-1:0]   steps_q;
	logic [lba_pkg::CNT_W-1:0]   freed_q;
	logic [lba_pkg::CNT_W-1:0]   free_q;
	logic [lba_pkg::CNT_W-1:0]   fcnt_q;
	logic [lba_pkg::STAT_W-1:0]  r_status_q;
	logic [lba_pkg::BIDX_W-1:0]  r_start_q;
	logic [lba_pkg::CNT_W-1:0]   r_used_q;
	logic                        out_valid_q;
	logic [lba_pkg::STAT_W-1:0]  status_q;
	logic [lba_pkg::START_W-1:0] start_q;
	logic [lba_pkg::CNT_W-1:0]   used_q;

	logic [lba_pkg::BIDX_W-1:0] link_rd_addr;
	logic [lba_pkg::LINK_W-1:0] link_rd;
	lba_pkg::link_wr_t          link_wr;
	logic [lba_pkg::FIDX_W-1:0] file_rd_addr;
	lba_pkg::file_rd_t          file_rd;
	lba_pkg::file_wr_t          file_wr;

	logic [lba_pkg::FIDX_W-1:0] chk_slot;
	logic [lba_pkg::BIDX_W-1:0] blk_idx;
	logic                       take;
	logic                       accept;
	logic                       res_ok;

	lba_link_mem u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (link_rd_addr),
		.wr      (link_wr),
		.rd_data (link_rd)
	);

	lba_file_mem u_file (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (file_rd_addr),
		.wr      (file_wr),
		.rd      (file_rd)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign res_ok   = !out_valid_q || !out_stall;

	// The entry checked in a scan cycle is the one read in the cycle before.
	assign chk_slot = lba_pkg::FIDX_W'(sidx_q - 1'b1);
	assign blk_idx  = lba_pkg::BIDX_W'(bidx_q - 1'b1);
	assign take     = (state_q == S_ASCAN) && (bidx_q != '0) && (link_rd == lba_pkg::LINK_FREE);

	// Memory addresses and write requests for the current step.
	always_comb begin
		file_rd_addr  = sidx_q[lba_pkg::FIDX_W-1:0];
		link_rd_addr  = (state_q == S_WRD) ? cur_q[lba_pkg::BIDX_W-1:0]
		                                   : bidx_q[lba_pkg::BIDX_W-1:0];
		link_wr       = '0;
		file_wr       = '0;
		unique case (state_q)
			S_ASCAN: begin
				if (take && (taken_q != '0)) begin
					link_wr.en   = 1'b1;
					link_wr.addr = prev_q;
					link_wr.data = lba_pkg::LINK_W'(blk_idx);
				end
			end
			S_AEND: begin
				link_wr.en    = 1'b1;
				link_wr.addr  = prev_q;
				link_wr.data  = lba_pkg::LINK_END;
				file_wr.set   = 1'b1;
				file_wr.addr  = hslot_q;
				file_wr.id    = id_q;
				file_wr.start = first_q;
			end
			S_WCK: begin
				if (link_rd != lba_pkg::LINK_FREE) begin
					link_wr.en   = 1'b1;
					link_wr.addr = cur_q[lba_pkg::BIDX_W-1:0];
					link_wr.data = lba_pkg::LINK_FREE;
				end
			end
			S_WFIN: begin
				file_wr.clr  = 1'b1;
				file_wr.addr = mslot_q;
			end
			default: begin
			end
		endcase
	end

	// Command sequencer, counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= lba_pkg::CNT_W'(lba_pkg::NUM_BLOCKS);
			fcnt_q      <= '0;
			out_valid_q <= 1'b0;
			sidx_q      <= '0;
			found_q     <= 1'b0;
			hole_q      <= 1'b0;
			bidx_q      <= '0;
			taken_q     <= '0;
			steps_q     <= '0;
			freed_q     <= '0;
		end else begin
			// The response state reloads the result register itself.
			if (out_valid_q && !out_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd;
						id_q    <= file_id;
						size_q  <= alloc_size;
						sidx_q  <= '0;
						found_q <= 1'b0;
						hole_q  <= 1'b0;
						r_start_q <= '0;
						r_used_q  <= '0;
						if (cmd == lba_pkg::CMD_CREATE && alloc_size == '0) begin
							r_status_q <= lba_pkg::ST_BAD_SIZE;
							state_q    <= S_RESP;
						end else if (cmd == lba_pkg::CMD_CREATE &&
						             fcnt_q >= lba_pkg::CNT_W'(lba_pkg::NUM_FILES)) begin
							r_status_q <= lba_pkg::ST_FULL;
							state_q    <= S_RESP;
						end else begin
							state_q <= S_FSCAN;
						end
					end
				end
				S_FSCAN: begin
					if (sidx_q != '0) begin
						if (file_rd.vld && file_rd.id == id_q) begin
							found_q  <= 1'b1;
							mslot_q  <= chk_slot;
							fstart_q <= file_rd.start;
						end else if (!file_rd.vld && !hole_q) begin
							hole_q  <= 1'b1;
							hslot_q <= chk_slot;
						end
					end
					if (sidx_q == (lba_pkg::FIDX_W+1)'(lba_pkg::NUM_FILES)) begin
						state_q <= S_DECIDE;
					end else begin
						sidx_q <= sidx_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (cmd_q == lba_pkg::CMD_CREATE) begin
						if (found_q) begin
							r_status_q <= lba_pkg::ST_EXISTS;
							state_q    <= S_RESP;
						end else if ({1'b0, free_q} < size_q) begin
							r_status_q <= lba_pkg::ST_TOO_FEW;
							state_q    <= S_RESP;
						end else begin
							bidx_q  <= '0;
							taken_q <= '0;
							state_q <= S_ASCAN;
						end
					end else begin
						if (!found_q) begin
							r_status_q <= lba_pkg::ST_NOT_FOUND;
							state_q    <= S_RESP;
						end else begin
							cur_q   <= lba_pkg::LINK_W'(fstart_q);
							steps_q <= '0;
							freed_q <= '0;
							state_q <= S_WRD;
						end
					end
				end
				S_ASCAN: begin
					if (bidx_q != (lba_pkg::BIDX_W+1)'(lba_pkg::NUM_BLOCKS)) begin
						bidx_q <= bidx_q + 1'b1;
					end
					if (take) begin
						if (taken_q == '0) begin
							first_q <= blk_idx;
						end
						prev_q  <= blk_idx;
						taken_q <= taken_q + 1'b1;
						if (({1'b0, taken_q} + 8'd1) == size_q) begin
							state_q <= S_AEND;
						end
					end
				end
				S_AEND: begin
					free_q     <= free_q - taken_q;
					fcnt_q     <= fcnt_q + 1'b1;
					r_status_q <= lba_pkg::ST_OK;
					r_start_q  <= first_q;
					r_used_q   <= taken_q;
					state_q    <= S_RESP;
				end
				S_WRD: begin
					if (cur_q >= lba_pkg::LINK_W'(lba_pkg::NUM_BLOCKS) ||
					    steps_q == lba_pkg::CNT_W'(lba_pkg::NUM_BLOCKS)) begin
						state_q <= S_WFIN;
					end else begin
						state_q <= S_WCK;
					end
				end
				S_WCK: begin
					if (link_rd == lba_pkg::LINK_FREE) begin
						state_q <= S_WFIN;
					end else begin
						freed_q <= freed_q + 1'b1;
						if (link_rd == lba_pkg::LINK_END) begin
							state_q <= S_WFIN;
						end else begin
							cur_q   <= link_rd;
							steps_q <= steps_q + 1'b1;
							state_q <= S_WRD;
						end
					end
				end
				S_WFIN: begin
					free_q <= free_q + freed_q;
					if (fcnt_q != '0) begin
						fcnt_q <= fcnt_q - 1'b1;
					end
					r_status_q <= lba_pkg::ST_OK;
					r_start_q  <= fstart_q;
					r_used_q   <= freed_q;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (res_ok) begin
						out_valid_q <= 1'b1;
						status_q    <= r_status_q;
						start_q     <= lba_pkg::START_W'(r_start_q);
						used_q      <= r_used_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign start_block = start_q;
	assign blocks_used = used_q;

	// Counters never leave their ranges.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= lba_pkg::CNT_W'(lba_pkg::NUM_BLOCKS))
		else $error("free block count out of range");

	a_fcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= lba_pkg::CNT_W'(lba_pkg::NUM_FILES))
		else $error("file count out of range");

	// A failed command reports zero start and count.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != lba_pkg::ST_OK) |-> (start_block == '0 && blocks_used == '0))
		else $error("failed command with nonzero fields");

	// An accepted command makes the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command accepted without going busy");

endmodule
`default_nettype wire
